// ----- hw/rtl/cta_pkg.sv -----
// Shared types and constants for the client table with aging.
// Item and result structs, status codes, controller command bundle.
// No dependencies.
package cta_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 10;
  localparam logic [31:0] TIMEOUT_RESET     = 32'd60000;

  localparam logic       FUNC_SEEN  = 1'b0;
  localparam logic       FUNC_SWEEP = 1'b1;

  localparam logic [1:0] ST_REFRESHED = 2'd0;
  localparam logic [1:0] ST_ADDED     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_SWEPT     = 2'd3;

  typedef struct packed {
    logic        func;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [31:0] now_ticks;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot;
    logic [3:0] removed_count;
    logic [3:0] live_count;
  } out_t;

  // controller -> datapath step strobes
  typedef struct packed {
    logic capture;
    logic compare;
    logic select;
    logic update;
  } cmd_t;

endpackage

// ----- hw/rtl/cta_ctrl.sv -----
// Sequencer for the client table: idle, compare, select, update.
// Depends on cta_pkg (cmd_t).
module cta_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output cta_pkg::cmd_t cmd
);
  import cta_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_SEL  = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_SEL;
      S_SEL:   state_nxt = S_UPD;
      S_UPD:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy        = (state_r != S_IDLE);
  assign cmd.capture = start && (state_r == S_IDLE);
  assign cmd.compare = (state_r == S_CMP);
  assign cmd.select  = (state_r == S_SEL);
  assign cmd.update  = (state_r == S_UPD);

`ifndef SYNTHESIS
  a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_CMP))
    else $error("accepted transaction did not enter compare");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_upd_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |=> (state_r == S_IDLE))
    else $error("update step not followed by idle");
`endif

endmodule

// ----- hw/rtl/cta_dp.sv -----
// Datapath of the client table: entry cells, parallel match/age compare,
// priority select, counts, update and result register. Depends on cta_pkg.
module cta_dp #(
  parameter int unsigned N = cta_pkg::TABLE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cta_pkg::cmd_t cmd,
  input  cta_pkg::in_t  in_item,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata,
  output logic          out_valid,
  output cta_pkg::out_t out_item
);
  import cta_pkg::*;

  localparam int unsigned IDX_W = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned CNT_W = $clog2(N + 1);

  logic [31:0]      timeout_r;
  in_t              item_r;

  logic [N-1:0]     valid_r;
  logic [31:0]      addr_r [N];
  logic [15:0]      port_r [N];
  logic [31:0]      seen_r [N];

  // compare stage results
  logic [N-1:0]     hit_r, hit_nxt;
  logic [N-1:0]     aged_r, aged_nxt;
  // select stage results
  logic             hit_found_r, hit_found_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] removed_r, removed_nxt;

  logic             out_valid_r;
  out_t             out_r, out_nxt;
  logic [CNT_W-1:0] active;

  function automatic logic [CNT_W-1:0] popcnt(input logic [N-1:0] v);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int k = 0; k < N; k++) c = c + CNT_W'(v[k]);
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n)      timeout_r <= TIMEOUT_RESET;
    else if (cfg_we) timeout_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
  end

  // per-cell compares, each cell against the captured item
  always_comb begin
    logic [31:0] age;
    for (int k = 0; k < N; k++) begin
      age         = item_r.now_ticks - seen_r[k];
      hit_nxt[k]  = valid_r[k] && (addr_r[k] == item_r.peer_addr) &&
                    (port_r[k] == item_r.peer_port);
      aged_nxt[k] = valid_r[k] && (age > timeout_r);
    end
  end

  // lowest-index hit and lowest free slot
  always_comb begin
    hit_found_nxt  = 1'b0;
    free_found_nxt = 1'b0;
    hit_idx_nxt    = '0;
    free_idx_nxt   = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (hit_r[k]) begin
        hit_found_nxt = 1'b1;
        hit_idx_nxt   = IDX_W'(k);
      end
      if (!valid_r[k]) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = IDX_W'(k);
      end
    end
    count_nxt   = popcnt(valid_r);
    removed_nxt = popcnt(aged_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      hit_r  <= hit_nxt;
      aged_r <= aged_nxt;
    end
    if (cmd.select) begin
      hit_found_r  <= hit_found_nxt;
      free_found_r <= free_found_nxt;
      hit_idx_r    <= hit_idx_nxt;
      free_idx_r   <= free_idx_nxt;
      count_r      <= count_nxt;
      removed_r    <= removed_nxt;
    end
  end

  // result for the update step
  always_comb begin
    active           = count_r;
    out_nxt.status   = ST_FULL;
    out_nxt.slot     = '0;
    out_nxt.removed_count = '0;
    if (item_r.func == FUNC_SWEEP) begin
      active                = count_r - removed_r;
      out_nxt.status        = ST_SWEPT;
      out_nxt.removed_count = 4'(removed_r);
    end else if (hit_found_r) begin
      out_nxt.status = ST_REFRESHED;
      out_nxt.slot   = 4'(hit_idx_r);
    end else if (free_found_r) begin
      active         = count_r + CNT_W'(1);
      out_nxt.status = ST_ADDED;
      out_nxt.slot   = 4'(free_idx_r);
    end
    out_nxt.live_count = 4'(active);
  end

  // entry cells
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.update) begin
      if (item_r.func == FUNC_SWEEP) begin
        valid_r <= valid_r & ~aged_r;
      end else if (!hit_found_r && free_found_r) begin
        for (int k = 0; k < N; k++)
          if (free_idx_r == IDX_W'(k)) valid_r[k] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && item_r.func == FUNC_SEEN) begin
      for (int k = 0; k < N; k++) begin
        if (hit_found_r) begin
          if (hit_idx_r == IDX_W'(k)) seen_r[k] <= item_r.now_ticks;
        end else if (free_found_r && free_idx_r == IDX_W'(k)) begin
          addr_r[k] <= item_r.peer_addr;
          port_r[k] <= item_r.peer_port;
          seen_r[k] <= item_r.now_ticks;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.update;
  end

  always_ff @(posedge clk) begin
    if (cmd.update) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_update_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid_r)
    else $error("update step produced no result");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_FULL) |-> (&valid_r))
    else $error("table full reported with a free slot");
`endif

endmodule

// ----- hw/rtl/client_table_with_aging.sv -----
// Top level of the client table with idle-timeout aging.
// Instantiates cta_ctrl and cta_dp; types from cta_pkg.
//
//  channel  ports                     handshake
//  -------  ------------------------  --------------------------------------
//  input    start, busy, in_item      accepted at edge with start && !busy
//  result   out_valid, out_item       one-cycle strobe, cannot be held off
//  config   cfg_we, cfg_wdata         idle timeout written when cfg_we high
//
// Each transaction runs through the accept edge, then the compare, select and
// update steps of the controller; the next start is taken in the cycle after
// update. The result register loads at update and shows while the controller
// is back in idle, in parallel with the next accept. The three steps are cell
// compare, priority select with population counts, and table update.
// Reset (rst_n low, synchronous) clears all valid marks and sets the idle
// timeout to 60000 ticks; entry contents are not cleared.
// The receiver cannot stall, so results never wait.
module client_table_with_aging #(
  parameter int unsigned TABLE_ENTRIES = cta_pkg::TABLE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  // input channel
  input  logic          start,
  output logic          busy,
  input  cta_pkg::in_t  in_item,
  // result channel
  output logic          out_valid,
  output cta_pkg::out_t out_item,
  // configuration
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata
);
  import cta_pkg::*;

  cmd_t cmd;

  // sequencer: one-hot FSM, issues one step strobe per cycle while a transaction is in progress
  cta_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // table cells, compare/select logic, timeout register, result register
  cta_dp #(
    .N (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- tb/cta_table_checker.sv -----
// Checker for the client table with aging: watches the input, result and
// config channels, predicts each result from a mirror of the table, compares.
// Depends on cta_pkg (in_t, out_t, status and func codes, table size).
module cta_table_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  cta_pkg::in_t  in_item,
  input  logic          out_valid,
  input  cta_pkg::out_t out_item,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata,
  output int unsigned   outstanding,
  output int unsigned   error_count
);
  import cta_pkg::*;

  localparam int unsigned N = TABLE_ENTRIES_DEF;

  logic        tab_valid [N];
  logic [31:0] tab_ip    [N];
  logic [15:0] tab_port  [N];
  logic [31:0] tab_seen  [N];
  logic [31:0] timeout_ticks;

  out_t expected_results [$];
  out_t want;

  // Applies one transaction to the mirror and returns the result it reports.
  function automatic out_t predict_table_step(in_t it);
    out_t        r;
    int          hit;
    int          free_idx;
    int unsigned removed;
    int unsigned active;
    logic [31:0] age;
    r        = '0;
    hit      = -1;
    free_idx = -1;
    removed  = 0;
    active   = 0;
    if (it.func == FUNC_SWEEP) begin
      for (int k = 0; k < N; k++) begin
        age = it.now_ticks - tab_seen[k];
        if (tab_valid[k] && age > timeout_ticks) begin
          tab_valid[k] = 1'b0;
          removed++;
        end
      end
      r.status = ST_SWEPT;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (tab_valid[k]) begin
          if (hit < 0 && tab_ip[k] == it.peer_addr && tab_port[k] == it.peer_port)
            hit = k;
        end else if (free_idx < 0) begin
          free_idx = k;
        end
      end
      if (hit >= 0) begin
        tab_seen[hit] = it.now_ticks;
        r.status      = ST_REFRESHED;
        r.slot        = 4'(hit);
      end else if (free_idx >= 0) begin
        tab_ip[free_idx]    = it.peer_addr;
        tab_port[free_idx]  = it.peer_port;
        tab_seen[free_idx]  = it.now_ticks;
        tab_valid[free_idx] = 1'b1;
        r.status            = ST_ADDED;
        r.slot              = 4'(free_idx);
      end else begin
        r.status = ST_FULL;
      end
    end
    for (int k = 0; k < N; k++)
      if (tab_valid[k]) active++;
    r.removed_count = 4'(removed);
    r.live_count    = 4'(active);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [3:0] exp_v,
                             input logic [3:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
      error_count++;
    end
  endtask

  // Channels only move at the rising edge, so the falling edge sees what the
  // next rising edge will accept.
  always @(negedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) tab_valid[k] = 1'b0;
      timeout_ticks = TIMEOUT_RESET;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %p", $time, out_item);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 4'(want.status), 4'(out_item.status));
          check_field("slot", want.slot, out_item.slot);
          check_field("removed_count", want.removed_count, out_item.removed_count);
          check_field("live_count", want.live_count, out_item.live_count);
        end
      end
      if (cfg_we) timeout_ticks = cfg_wdata;
      if (start && !busy) expected_results.push_back(predict_table_step(in_item));
    end
    outstanding = expected_results.size();
  end

endmodule

// ----- tb/tb_client_table_with_aging.sv -----
// Top of the client table testbench: clock, reset, stimulus and verdict.
// Depends on cta_pkg, client_table_with_aging and cta_table_checker.
module tb_client_table_with_aging;
  import cta_pkg::*;

  localparam int unsigned POOL_SIZE    = 14;  // more clients than slots, so the table fills
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned QUIET_AFTER  = 50;  // last phase: no gaps past this item
  localparam int unsigned SETTLE_CYCLES = 6;  // room for the compare, select and update steps plus the strobe

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_item;
  logic        out_valid;
  out_t        out_item;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  int unsigned outstanding;
  int unsigned error_count;

  // client pool for the random part, reshuffled every phase
  logic [31:0] pool_ip   [POOL_SIZE];
  logic [15:0] pool_port [POOL_SIZE];
  logic [31:0] tick_now;
  logic [31:0] tick_step_max;
  logic [31:0] timeout_list [7];
  logic        gaps_on;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  client_table_with_aging dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cta_table_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .error_count (error_count)
  );

  // Hold start high until busy is seen low at a falling edge; the following
  // rising edge accepts the transaction. Returns right at that edge, so a
  // back-to-back send keeps start high with a single assignment.
  task automatic send_item(input in_t it);
    start   <= 1'b1;
    in_item <= it;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic idle_cycles(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Sender pause: nothing in flight, then a settle wait for the block to go idle.
  task automatic drain();
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic in_t seen_item(input logic [31:0] ip, input logic [15:0] port,
                                    input logic [31:0] now);
    in_t it;
    it.func      = FUNC_SEEN;
    it.peer_addr = ip;
    it.peer_port = port;
    it.now_ticks = now;
    return it;
  endfunction

  function automatic in_t sweep_item(input logic [31:0] now);
    in_t it;
    it.func      = FUNC_SWEEP;
    it.peer_addr = $urandom();          // ignored by a sweep, still toggled
    it.peer_port = 16'($urandom());
    it.now_ticks = now;
    return it;
  endfunction

  // Pairs of pool entries often share an address and differ only in port,
  // so a match has to check both fields.
  task automatic shuffle_pool();
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_ip[k]   = $urandom();
      pool_port[k] = 16'($urandom_range(0, 65535));
      if (k % 2 == 1 && $urandom_range(0, 1) == 1) pool_ip[k] = pool_ip[k - 1];
    end
  endtask

  // Mostly seen transactions from the pool with a clock that moves forward
  // in steps scaled to the timeout, so entries age out at a steady rate.
  // Now and then the clock jumps anywhere, backwards and across the wrap too.
  function automatic in_t random_item();
    int unsigned pick;
    int unsigned roll;
    if ($urandom_range(0, 99) < 3) tick_now = $urandom();
    else tick_now = tick_now + $urandom_range(0, tick_step_max);
    roll = $urandom_range(0, 99);
    if (roll < 15) return sweep_item(tick_now);
    if (roll < 25) return seen_item($urandom(), 16'($urandom()), tick_now);
    pick = $urandom_range(0, POOL_SIZE - 1);
    return seen_item(pool_ip[pick], pool_port[pick], tick_now);
  endfunction

  initial begin
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    gaps_on   = 1'b1;
    tick_now  = '0;

    timeout_list[0] = TIMEOUT_RESET;
    timeout_list[1] = 32'd0;
    timeout_list[2] = 32'hFFFF_FFFF;
    timeout_list[3] = 32'd1;
    timeout_list[4] = 32'd5000;
    timeout_list[5] = $urandom();
    timeout_list[6] = TIMEOUT_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset timeout of 60000.
    send_item(seen_item(32'h0000_0000, 16'h0000, 32'd0));          // lowest slot
    send_item(seen_item(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(seen_item(32'hFFFF_FFFF, 16'hFFFF, 32'd5));           // refresh across the wrap
    send_item(seen_item(32'hFFFF_FFFF, 16'h0000, 32'd10));          // same address, new port
    send_item(seen_item(32'h0000_0000, 16'hFFFF, 32'd10));          // same port, other address
    for (int k = 0; k < 6; k++)
      send_item(seen_item(32'd100 + k, 16'(k), 32'd20));
    send_item(seen_item(32'h5555_5555, 16'hAAAA, 32'd30));          // table full
    send_item(sweep_item(32'd60000));                               // age equal to timeout stays
    send_item(sweep_item(32'd60001));                               // one past it goes
    send_item(seen_item(32'hAAAA_AAAA, 16'h5555, 32'd60001));       // reuse of the freed slot
    send_item(seen_item(32'hAAAA_AAAA, 16'h5555, 32'd60002));
    send_item(sweep_item(32'h7FFF_FFFF));                           // clears the whole table
    send_item(sweep_item(32'h8000_0000));                           // sweep of an empty table
    send_item(seen_item(32'h1234_5678, 16'h1234, 32'hFFFF_FFF0));
    send_item(sweep_item(32'd5));                                   // small age across the wrap
    send_item(sweep_item(32'hFFFF_FFEF));                           // now before last seen
    drain();

    // Random part, one phase per timeout setting.
    for (int p = 0; p < 7; p++) begin
      write_timeout(timeout_list[p]);
      tick_step_max = (timeout_list[p] >> 2) + 32'd2;
      tick_now      = (p % 2 == 1) ? 32'hFFFF_FF00 : $urandom();
      shuffle_pool();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_item(random_item());
        if (i % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
        if (p == 6 && i >= QUIET_AFTER) gaps_on = 1'b0;
        if (i == PHASE_ITEMS / 2 && p < 6) drain();
        else if (gaps_on && $urandom_range(0, 4) == 0) idle_cycles($urandom_range(1, 11));
      end
      drain();
    end

    // drain() above already waited out the in-flight results.
    if (error_count == 0) begin
      $display("tb_client_table_with_aging: clean");
    end else begin
      $display("tb_client_table_with_aging: errors");
    end
    $finish;
  end

  // Watchdog: ends the run with an error verdict if it does not finish.
  initial begin
    #(12 * 300000);
    $display("tb_client_table_with_aging: errors");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/cta_pkg.sv
hw/rtl/cta_ctrl.sv
hw/rtl/cta_dp.sv
hw/rtl/client_table_with_aging.sv
tb/cta_table_checker.sv
tb/tb_client_table_with_aging.sv
